// File: sv/go_back_n_sender_top_macros.svh
// ----------------------------------------------------------------------------
// Go-Back-N sender assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_TOP_MACROS_SVH
`define GO_BACK_N_SENDER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked on every clock edge outside reset.
`define GBN_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("go_back_n_sender assertion failed");
// Checked during reset as well.
`define GBN_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("go_back_n_sender assertion failed");
`else
`define GBN_ASSERT(lbl, clk, rst, prop)
`define GBN_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: sv/gbn_pkg.sv
// ----------------------------------------------------------------------------
// Go-Back-N sender package
// Shared types, codes, defaults and the payload byte sum.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int DEF_MAX_WINDOW  = 32;
  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int PAYLOAD_BYTES   = 20;
  localparam logic [31:0] SEND_ACK_NUM = 32'd999;
  localparam logic [5:0]  WINDOW_RESET = 6'd8;

  localparam logic [1:0] CMD_NEW     = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  localparam logic [1:0] TIMER_LEAVE = 2'd0;
  localparam logic [1:0] TIMER_START = 2'd1;
  localparam logic [1:0] TIMER_STOP  = 2'd2;

  typedef enum logic [1:0] {
    OP_NEW,
    OP_ACK,
    OP_TIMEOUT,
    OP_NONE
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL_CHK,
    ST_FILL_WAIT,
    ST_NEW_MSG,
    ST_ACK_RD,
    ST_ACK_CHK,
    ST_RTX_RD,
    ST_RTX_EMIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] low;
    logic [63:0] mid;
    logic [31:0] high;
    logic [31:0] pseq;
    logic [31:0] pack;
    logic [31:0] pchk;
  } item_t;

  typedef struct packed {
    logic        sent;
    logic [31:0] seq;
    logic [31:0] chk;
    logic [63:0] low;
    logic [63:0] mid;
    logic [31:0] high;
  } packet_t;

  typedef struct packed {
    logic        strobe;
    packet_t     pkt;
    logic [1:0]  timer;
    logic        dropped;
    logic        rejected;
    logic        last;
  } result_t;

  function automatic logic [31:0] byte_sum(input logic [63:0] lo, input logic [63:0] mid,
                                           input logic [31:0] hi);
    logic [159:0] all;
    logic [31:0]  s;
    all = {hi, mid, lo};
    s   = '0;
    for (int i = 0; i < 20; i++) begin
      if (i < PAYLOAD_BYTES) s = s + 32'(all[8*i +: 8]);
    end
    return s;
  endfunction

endpackage

// File: sv/gbn_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: sv/gbn_front.sv
// ----------------------------------------------------------------------------
// Go-Back-N sender front end
// Accepts command beats, decodes the command and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module gbn_front
  import gbn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [63:0] payload_low,
  input  logic [63:0] payload_mid,
  input  logic [31:0] payload_high,
  input  logic [31:0] pkt_seq,
  input  logic [31:0] pkt_ack,
  input  logic [31:0] pkt_checksum,
  output logic        item_valid,
  output item_t       item,
  input  logic        pop
);

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  op_t         op;

  always_comb begin
    case (command)
      CMD_NEW:     op = OP_NEW;
      CMD_ACK:     op = OP_ACK;
      CMD_TIMEOUT: op = OP_TIMEOUT;
      default:     op = OP_NONE;
    endcase
  end

  assign busy       = (count == 2'd2);
  assign push       = start && !busy;
  assign item_valid = (count != 2'd0);
  assign item       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{op: op, low: payload_low, mid: payload_mid, high: payload_high,
                         pseq: pkt_seq, pack: pkt_ack, pchk: pkt_checksum};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: sv/gbn_back.sv
// ----------------------------------------------------------------------------
// Go-Back-N sender back end
// Sequencer that runs the window, the message queue and the result stream.
// ----------------------------------------------------------------------------
`include "go_back_n_sender_top_macros.svh"

module gbn_back
  import gbn_pkg::*;
#(
  parameter int MaxWindow  = DEF_MAX_WINDOW,
  parameter int QueueDepth = DEF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [5:0] win_limit,
  input  logic       item_valid,
  input  item_t      item,
  output logic       pop,
  output result_t    res
);

  localparam int IW = $clog2(MaxWindow + 1);
  localparam int SW = MaxWindow > 1 ? $clog2(MaxWindow) : 1;
  localparam int CW = $clog2(QueueDepth + 1);
  localparam int HW = QueueDepth > 1 ? $clog2(QueueDepth) : 1;
  localparam int WIN_W = 192;
  localparam int Q_W   = 160;

  state_t          state, state_next;
  item_t           cur;
  logic [SW-1:0]   oldest;
  logic [IW-1:0]   in_flight;
  logic [31:0]     next_seq;
  logic [HW-1:0]   q_head;
  logic [CW-1:0]   q_count;
  logic [IW-1:0]   k;
  logic            was_empty;
  logic            chk_ok;
  logic            dropped_r;
  logic            rejected_r;
  logic [1:0]      timer_r;
  logic            pend_valid;
  packet_t         pend;

  logic [IW-1:0]   eff;
  logic            room;
  logic            ack_ok;
  logic [SW-1:0]   win_tail;
  logic [HW-1:0]   q_tail;
  logic            win_we;
  logic [SW-1:0]   win_raddr;
  logic [WIN_W-1:0] win_wdata, win_rdata;
  logic            q_we;
  logic [Q_W-1:0]  q_wdata, q_rdata;
  logic            em_valid;
  packet_t         em;
  logic [159:0]    src;
  logic [31:0]     src_seq;
  logic [1:0]      final_timer;

  function automatic logic [SW-1:0] win_wrap(input logic [IW:0] v);
    if (int'(v) >= MaxWindow) return SW'(int'(v) - MaxWindow);
    return SW'(v);
  endfunction

  function automatic logic [HW-1:0] q_wrap(input logic [CW:0] v);
    if (int'(v) >= QueueDepth) return HW'(int'(v) - QueueDepth);
    return HW'(v);
  endfunction

  always_comb begin
    if (int'(win_limit) > MaxWindow) eff = IW'(MaxWindow);
    else if (win_limit == 6'd0) eff = IW'(1);
    else eff = IW'(win_limit);
  end

  assign room     = in_flight < eff;
  assign win_tail = win_wrap((IW+1)'(oldest) + (IW+1)'(in_flight));
  assign q_tail   = q_wrap((CW+1)'(q_head) + (CW+1)'(q_count));
  assign ack_ok   = (in_flight != '0) && chk_ok && (cur.pack == win_rdata[191:160]);

  // Window and queue stores.
  gbn_ram #(.WIDTH(WIN_W), .DEPTH(MaxWindow)) u_win (
    .clk(clk), .we(win_we), .waddr(win_tail), .wdata(win_wdata),
    .raddr(win_raddr), .rdata(win_rdata)
  );

  gbn_ram #(.WIDTH(Q_W), .DEPTH(QueueDepth)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_tail), .wdata(q_wdata),
    .raddr(q_head), .rdata(q_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          case (item.op)
            OP_NEW:     state_next = ST_FILL_CHK;
            OP_ACK:     state_next = ST_ACK_RD;
            OP_TIMEOUT: state_next = ST_RTX_RD;
            default:    state_next = ST_FINISH;
          endcase
        end
      end
      ST_FILL_CHK: begin
        if (q_count != '0 && room) state_next = ST_FILL_WAIT;
        else if (cur.op == OP_NEW) state_next = ST_NEW_MSG;
        else state_next = ST_FINISH;
      end
      ST_FILL_WAIT: state_next = ST_FILL_CHK;
      ST_NEW_MSG:   state_next = ST_FINISH;
      ST_ACK_RD:    state_next = ST_ACK_CHK;
      ST_ACK_CHK:   state_next = ack_ok ? ST_FILL_CHK : ST_FINISH;
      ST_RTX_RD:    state_next = (k < in_flight) ? ST_RTX_EMIT : ST_FINISH;
      ST_RTX_EMIT:  state_next = ST_RTX_RD;
      ST_FINISH:    state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: store controls and the packet being emitted.
  always_comb begin
    pop       = 1'b0;
    win_we    = 1'b0;
    q_we      = 1'b0;
    em_valid  = 1'b0;
    win_raddr = oldest;
    src       = {cur.high, cur.mid, cur.low};
    src_seq   = next_seq;
    case (state)
      ST_IDLE: pop = item_valid;
      ST_FILL_WAIT: begin
        src      = q_rdata;
        win_we   = 1'b1;
        em_valid = 1'b1;
      end
      ST_NEW_MSG: begin
        win_we   = room;
        em_valid = room;
        q_we     = !room && (q_count < CW'(QueueDepth));
      end
      ST_RTX_RD: win_raddr = win_wrap((IW+1)'(oldest) + (IW+1)'(k));
      ST_RTX_EMIT: begin
        src      = win_rdata[159:0];
        src_seq  = win_rdata[191:160];
        em_valid = 1'b1;
      end
      default: ;
    endcase
    win_wdata = {src_seq, src};
    q_wdata   = {cur.high, cur.mid, cur.low};
    em.sent   = 1'b1;
    em.seq    = src_seq;
    em.chk    = byte_sum(src[63:0], src[127:64], src[159:128]) + src_seq + SEND_ACK_NUM;
    em.low    = src[63:0];
    em.mid    = src[127:64];
    em.high   = src[159:128];
  end

  always_comb begin
    case (cur.op)
      OP_NEW:     final_timer = timer_r;
      OP_ACK:     final_timer = rejected_r ? TIMER_LEAVE :
                                (in_flight != '0 ? TIMER_START : TIMER_STOP);
      OP_TIMEOUT: final_timer = (in_flight != '0) ? TIMER_START : TIMER_LEAVE;
      default:    final_timer = TIMER_LEAVE;
    endcase
  end

  // Payload registers and the result beat.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      cur       <= item;
      was_empty <= (in_flight == '0);
    end
    if (state == ST_ACK_RD) begin
      chk_ok <= (byte_sum(cur.low, cur.mid, cur.high) + cur.pseq + cur.pack) == cur.pchk;
    end
    if (em_valid) pend <= em;
    if (state == ST_NEW_MSG) begin
      timer_r <= (was_empty && (in_flight != '0 || room)) ? TIMER_START : TIMER_LEAVE;
    end
    res.strobe <= !rst && ((em_valid && pend_valid) || (state == ST_FINISH));
    if (pend_valid && (em_valid || state == ST_FINISH)) res.pkt <= pend;
    else res.pkt <= '0;
    if (state == ST_FINISH) begin
      res.timer    <= final_timer;
      res.dropped  <= dropped_r;
      res.rejected <= rejected_r;
      res.last     <= 1'b1;
    end else begin
      res.timer    <= TIMER_LEAVE;
      res.dropped  <= 1'b0;
      res.rejected <= 1'b0;
      res.last     <= 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      oldest     <= '0;
      in_flight  <= '0;
      next_seq   <= '0;
      q_head     <= '0;
      q_count    <= '0;
      k          <= '0;
      dropped_r  <= 1'b0;
      rejected_r <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      if (em_valid) pend_valid <= 1'b1;
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            k          <= '0;
            dropped_r  <= 1'b0;
            rejected_r <= 1'b0;
          end
        end
        ST_FILL_WAIT: begin
          q_head    <= q_wrap((CW+1)'(q_head) + (CW+1)'(1));
          q_count   <= q_count - CW'(1);
          in_flight <= in_flight + IW'(1);
          next_seq  <= next_seq + 32'd1;
        end
        ST_NEW_MSG: begin
          if (room) begin
            in_flight <= in_flight + IW'(1);
            next_seq  <= next_seq + 32'd1;
          end else if (q_count < CW'(QueueDepth)) begin
            q_count <= q_count + CW'(1);
          end else begin
            dropped_r <= 1'b1;
          end
        end
        ST_ACK_CHK: begin
          if (ack_ok) begin
            oldest    <= win_wrap((IW+1)'(oldest) + (IW+1)'(1));
            in_flight <= in_flight - IW'(1);
          end else begin
            rejected_r <= 1'b1;
          end
        end
        ST_RTX_RD: begin
          if (k < in_flight) k <= k + IW'(1);
        end
        ST_FINISH: pend_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  `GBN_ASSERT(a_empty_only_last, clk, rst, (res.strobe && !res.pkt.sent) |-> res.last)
  `GBN_ASSERT(a_drop_means_full, clk, rst,
              (res.strobe && res.dropped) |-> (q_count == CW'(QueueDepth)))
  `GBN_ASSERT(a_stop_means_empty, clk, rst,
              (res.strobe && res.timer == TIMER_STOP) |-> (in_flight == '0))
  `GBN_ASSERT_ALWAYS(a_window_bound, clk, rst || (int'(in_flight) <= MaxWindow))

endmodule

// File: sv/go_back_n_sender_top.sv
// ----------------------------------------------------------------------------
// Go-Back-N sender
// Sends queued messages through a sliding window and resends it on timeout.
// ----------------------------------------------------------------------------
// A command beat is taken at a clock edge where start is high and busy is low:
// command 0 offers a new 20-byte message, 1 delivers an ack packet, 2 reports
// a retransmit timeout. A front queue holds up to two beats, so busy rises only
// when the sequencer falls behind. Each beat yields one or more results, each
// shown for one cycle with result_strobe high; last_of_run marks the final one,
// which also carries timer_action, dropped and ack_rejected. The receiver cannot
// stall results. Each packet moved from the message queue takes one queue read
// and one window write, and a timeout reads back each packet in flight in turn
// through the single read port of the window store.
// cfg_we writes the window limit from cfg_data; write it only while idle.
// Reset (rst, synchronous) empties the window and the queue, zeroes the
// sequence counter and sets the window limit to 8; the stores need no clearing.
module go_back_n_sender_top
  import gbn_pkg::*;
#(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [63:0] payload_low,
  input  logic [63:0] payload_mid,
  input  logic [31:0] payload_high,
  input  logic [31:0] pkt_seq,
  input  logic [31:0] pkt_ack,
  input  logic [31:0] pkt_checksum,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_data,
  output logic        result_strobe,
  output logic        sent,
  output logic [31:0] out_seq,
  output logic [31:0] out_checksum,
  output logic [63:0] out_payload_low,
  output logic [63:0] out_payload_mid,
  output logic [31:0] out_payload_high,
  output logic [1:0]  timer_action,
  output logic        dropped,
  output logic        ack_rejected,
  output logic        last_of_run
);

  logic [5:0] window_reg;
  logic       item_valid;
  item_t      item;
  logic       pop;
  result_t    res;

  always_ff @(posedge clk) begin
    if (rst) window_reg <= WINDOW_RESET;
    else if (cfg_we) window_reg <= cfg_data;
  end

  gbn_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .payload_low(payload_low), .payload_mid(payload_mid), .payload_high(payload_high),
    .pkt_seq(pkt_seq), .pkt_ack(pkt_ack), .pkt_checksum(pkt_checksum),
    .item_valid(item_valid), .item(item), .pop(pop)
  );

  gbn_back #(.MaxWindow(MAX_WINDOW), .QueueDepth(QUEUE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .win_limit(window_reg), .item_valid(item_valid),
    .item(item), .pop(pop), .res(res)
  );

  assign result_strobe    = res.strobe;
  assign sent             = res.pkt.sent;
  assign out_seq          = res.pkt.seq;
  assign out_checksum     = res.pkt.chk;
  assign out_payload_low  = res.pkt.low;
  assign out_payload_mid  = res.pkt.mid;
  assign out_payload_high = res.pkt.high;
  assign timer_action     = res.timer;
  assign dropped          = res.dropped;
  assign ack_rejected     = res.rejected;
  assign last_of_run      = res.last;

endmodule
